// ===== rtl/core/rcwc_pkg.sv =====
// Shared types and constants for the Reno congestion window controller.
// No dependencies; referenced by scoped names from rtl/core modules.
package rcwc_pkg;

	localparam int SEGMENT_BYTES_DEF      = 1024;
	localparam int INITIAL_TIMEOUT_MS_DEF = 1000;

	localparam logic [31:0] THRESH_RESET      = 32'd65536;
	localparam logic [3:0]  DUP_THRESH_RESET  = 4'd3;
	localparam logic [15:0] RTO_FLOOR_RESET   = 16'd1000;
	localparam logic [15:0] RTO_CEIL_RESET    = 16'd60000;
	localparam logic [15:0] BACKOFF_RESET     = 16'd32000;
	localparam logic [7:0]  DUP_COUNT_MAX     = 8'd255;

	typedef enum logic [1:0] {
		PH_SLOW  = 2'd0,
		PH_AVOID = 2'd1,
		PH_RECOV = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		FN_NEW_ACK    = 2'd0,
		FN_DUP_ACK    = 2'd1,
		FN_TIMEOUT    = 2'd2,
		FN_RTT_SAMPLE = 2'd3
	} func_t;

	localparam logic [1:0] REG_DUP_THRESH = 2'd0;
	localparam logic [1:0] REG_RTO_FLOOR  = 2'd1;
	localparam logic [1:0] REG_RTO_CEIL   = 2'd2;
	localparam logic [1:0] REG_BACKOFF    = 2'd3;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

// ===== rtl/core/reno_congestion_window_control.sv =====
// Reno congestion window controller: one event in, one status result out.
// Depends on rtl/core/rcwc_pkg.sv for event codes, phases and reset values.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transfer: func
//   selects new ACK, duplicate ACK, timeout or RTT sample; rtt_sample is
//   used only for RTT samples. Output channel (out_valid/out_ready) carries
//   the window, threshold, phase, timeout and the two event flags after that
//   event. Configuration registers are written through wr_en/wr_index/wr_data;
//   the user must do so only while the block is idle, which it does not enforce.
//   After its input transfer, an event sits in the input register, then loads
//   the state and result registers once any stalled result has been taken.
//   Throughput is one event per cycle while results are taken; every state field
//   is updated in one pass of adds, compares and shifts from the input register.
//   When the receiver stalls, the result holds and the input register still
//   takes one more event, after which in_ready drops until out_ready returns.
//   Reset clears both pipeline slots and loads the reset window, threshold,
//   timer estimates and configuration defaults.
module reno_congestion_window_control #(
	parameter int SEGMENT_BYTES      = rcwc_pkg::SEGMENT_BYTES_DEF,
	parameter int INITIAL_TIMEOUT_MS = rcwc_pkg::INITIAL_TIMEOUT_MS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] rtt_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] window_bytes,
	output logic [31:0] slow_start_limit,
	output logic [1:0]  phase,
	output logic        retransmit_now,
	output logic [15:0] retx_timeout,
	output logic        sample_rejected,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data
);

	localparam logic [31:0] SEG_W     = 32'(SEGMENT_BYTES);
	localparam logic [31:0] TWO_SEG_W = 32'(2 * SEGMENT_BYTES);
	localparam logic [31:0] THR_SEG_W = 32'(3 * SEGMENT_BYTES);
	localparam logic [15:0] INIT_RTO  = 16'(INITIAL_TIMEOUT_MS);
	localparam logic [15:0] INIT_VAR  = 16'(INITIAL_TIMEOUT_MS / 2);

	logic [3:0]  dup_thresh_q;
	logic [15:0] rto_floor_q;
	logic [15:0] rto_ceil_q;
	logic [15:0] backoff_q;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] sample_s1;

	logic [31:0]     window_q;
	logic [31:0]     threshold_q;
	logic [31:0]     accum_q;
	rcwc_pkg::phase_t phase_q;
	logic [7:0]      dup_q;
	logic [15:0]     srtt_q;
	logic [15:0]     rttvar_q;
	logic [15:0]     rto_q;
	logic            out_valid_q;
	logic            retx_q;
	logic            rejected_q;

	logic [31:0]     window_d;
	logic [31:0]     threshold_d;
	logic [31:0]     accum_d;
	rcwc_pkg::phase_t phase_d;
	logic [7:0]      dup_d;
	logic [15:0]     srtt_d;
	logic [15:0]     rttvar_d;
	logic [15:0]     rto_d;
	logic            retx_d;
	logic            rejected_d;

	logic        advance;
	logic [31:0] halved;
	logic [31:0] win_plus_seg;
	logic [31:0] acc_plus_seg;
	logic [7:0]  dup_inc;
	logic [16:0] rto_dbl;
	logic [15:0] delta;
	logic [19:0] srtt_sum;
	logic [17:0] var_sum;
	logic [15:0] srtt_new;
	logic [15:0] var_new;
	logic [18:0] nrto;
	logic [18:0] nrto_fl;
	logic [18:0] nrto_cl;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		halved       = (window_q >> 1) > TWO_SEG_W ? (window_q >> 1) : TWO_SEG_W;
		win_plus_seg = rcwc_pkg::sat_add32(window_q, SEG_W);
		acc_plus_seg = rcwc_pkg::sat_add32(accum_q, SEG_W);
		dup_inc      = (dup_q < rcwc_pkg::DUP_COUNT_MAX) ? dup_q + 8'd1 : dup_q;
		rto_dbl      = {rto_q, 1'b0};
		delta        = (sample_s1 >= srtt_q) ? sample_s1 - srtt_q : srtt_q - sample_s1;
		srtt_sum     = 20'(srtt_q) * 20'd7 + 20'(sample_s1);
		var_sum      = 18'(rttvar_q) * 18'd3 + 18'(delta);
		srtt_new     = srtt_sum[18:3];
		var_new      = var_sum[17:2];
		nrto         = 19'(srtt_new) + 19'({var_new, 2'b00});
		nrto_fl      = (nrto < 19'(rto_floor_q)) ? 19'(rto_floor_q) : nrto;
		nrto_cl      = (nrto_fl > 19'(rto_ceil_q)) ? 19'(rto_ceil_q) : nrto_fl;

		window_d    = window_q;
		threshold_d = threshold_q;
		accum_d     = accum_q;
		phase_d     = phase_q;
		dup_d       = dup_q;
		srtt_d      = srtt_q;
		rttvar_d    = rttvar_q;
		rto_d       = rto_q;
		retx_d      = 1'b0;
		rejected_d  = 1'b0;

		case (rcwc_pkg::func_t'(func_s1))
			rcwc_pkg::FN_NEW_ACK: begin
				dup_d = '0;
				case (phase_q)
					rcwc_pkg::PH_SLOW: begin
						window_d = win_plus_seg;
						if (win_plus_seg >= threshold_q) begin
							phase_d = rcwc_pkg::PH_AVOID;
						end
					end
					rcwc_pkg::PH_AVOID: begin
						if (acc_plus_seg >= window_q) begin
							window_d = win_plus_seg;
							accum_d  = '0;
						end else begin
							accum_d = acc_plus_seg;
						end
					end
					rcwc_pkg::PH_RECOV: begin
						phase_d = rcwc_pkg::PH_AVOID;
						accum_d = '0;
					end
					default: begin
					end
				endcase
			end
			rcwc_pkg::FN_DUP_ACK: begin
				dup_d = dup_inc;
				if (dup_inc == 8'(dup_thresh_q)) begin
					threshold_d = halved;
					window_d    = rcwc_pkg::sat_add32(halved, THR_SEG_W);
					phase_d     = rcwc_pkg::PH_RECOV;
					retx_d      = 1'b1;
				end else if (dup_inc > 8'(dup_thresh_q) && phase_q == rcwc_pkg::PH_RECOV) begin
					window_d = win_plus_seg;
				end
			end
			rcwc_pkg::FN_TIMEOUT: begin
				threshold_d = halved;
				window_d    = SEG_W;
				phase_d     = rcwc_pkg::PH_SLOW;
				dup_d       = '0;
				if (rto_q < backoff_q) begin
					rto_d = rto_dbl[16] ? 16'hFFFF : rto_dbl[15:0];
				end
			end
			default: begin
				if (sample_s1 == 16'd0) begin
					rejected_d = 1'b1;
				end else begin
					srtt_d   = srtt_new;
					rttvar_d = var_new;
					rto_d    = nrto_cl[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_thresh_q <= rcwc_pkg::DUP_THRESH_RESET;
			rto_floor_q  <= rcwc_pkg::RTO_FLOOR_RESET;
			rto_ceil_q   <= rcwc_pkg::RTO_CEIL_RESET;
			backoff_q    <= rcwc_pkg::BACKOFF_RESET;
		end else if (wr_en) begin
			case (wr_index)
				rcwc_pkg::REG_DUP_THRESH: dup_thresh_q <= wr_data[3:0];
				rcwc_pkg::REG_RTO_FLOOR:  rto_floor_q  <= wr_data;
				rcwc_pkg::REG_RTO_CEIL:   rto_ceil_q   <= wr_data;
				rcwc_pkg::REG_BACKOFF:    backoff_q    <= wr_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1   <= func;
			sample_s1 <= rtt_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= SEG_W;
			threshold_q <= rcwc_pkg::THRESH_RESET;
			accum_q     <= '0;
			phase_q     <= rcwc_pkg::PH_SLOW;
			dup_q       <= '0;
			srtt_q      <= INIT_RTO;
			rttvar_q    <= INIT_VAR;
			rto_q       <= INIT_RTO;
			out_valid_q <= 1'b0;
			retx_q      <= 1'b0;
			rejected_q  <= 1'b0;
		end else begin
			if (advance) begin
				window_q    <= window_d;
				threshold_q <= threshold_d;
				accum_q     <= accum_d;
				phase_q     <= phase_d;
				dup_q       <= dup_d;
				srtt_q      <= srtt_d;
				rttvar_q    <= rttvar_d;
				rto_q       <= rto_d;
				retx_q      <= retx_d;
				rejected_q  <= rejected_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = out_valid_q;
	assign window_bytes     = window_q;
	assign slow_start_limit = threshold_q;
	assign phase            = phase_q;
	assign retransmit_now   = retx_q;
	assign retx_timeout     = rto_q;
	assign sample_rejected  = rejected_q;

	a_retx_in_recovery: assert property (@(posedge clk) disable iff (!arst_n)
		retx_q |-> phase_q == rcwc_pkg::PH_RECOV)
		else $error("fast retransmit flagged outside fast recovery");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(retx_q && rejected_q))
		else $error("retransmit and rejected sample flagged together");

	a_window_floor: assert property (@(posedge clk) disable iff (!arst_n)
		window_q >= SEG_W)
		else $error("congestion window below one segment");

	a_threshold_floor: assert property (@(posedge clk) disable iff (!arst_n)
		threshold_q >= TWO_SEG_W || threshold_q == rcwc_pkg::THRESH_RESET)
		else $error("slow-start threshold below two segments");

	a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(window_q) && $stable(rto_q) && $stable(dup_q))
		else $error("state changed while a result was stalled");

endmodule
